// ===== src/scpg_pkg.sv =====
// Shared types, constants and helper functions for the speed cap profile generator.
// Used by every module of the block; depends on nothing.
package scpg_pkg;

    localparam int HORIZON_SECONDS = 10;
    localparam int TW = 6;
    localparam logic [TW-1:0] LAST_T = TW'(HORIZON_SECONDS - 1);

    localparam int QDEPTH = 2;
    localparam int QPW = $clog2(QDEPTH);
    localparam int QCW = $clog2(QDEPTH + 1);

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BORROW_LIMIT = 3'd0;
    localparam logic [2:0] REG_NORMAL_LIMIT = 3'd1;
    localparam logic [2:0] REG_COMFORT_DECEL = 3'd2;
    localparam logic [2:0] REG_MAX_DECEL = 3'd3;
    localparam logic [2:0] REG_DEST_MARGIN = 3'd4;

    localparam logic [15:0] RST_BORROW_LIMIT = 16'd4167;
    localparam logic [15:0] RST_NORMAL_LIMIT = 16'd2778;
    localparam logic [15:0] RST_COMFORT_DECEL = 16'hF9C0;
    localparam logic [15:0] RST_MAX_DECEL = 16'hF060;
    localparam logic [16:0] RST_DEST_MARGIN = 17'd1000;

    typedef enum logic [1:0] {
        ST_POINT       = 2'd0,
        ST_NO_LENGTH   = 2'd1,
        ST_DESTINATION = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        K_NO_LENGTH,
        K_DESTINATION,
        K_AT_POINT,
        K_BELOW,
        K_RAMP
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [30:0] stop_dist;
        logic [15:0] speed;
        logic [15:0] limit;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_PREP1,
        BK_PREP2,
        BK_PREP3,
        BK_DIV,
        BK_SQRT,
        BK_EMIT,
        BK_EMIT_ERR
    } back_state_t;

    function automatic logic signed [51:0] smax(input logic signed [51:0] x,
                                                input logic signed [51:0] y);
        return (x > y) ? x : y;
    endfunction

    function automatic logic [15:0] clamp_bound(input logic signed [51:0] x);
        logic [15:0] r;
        if (x < 52'sd0) begin
            r = 16'd0;
        end
        else if (x > 52'sd65535) begin
            r = 16'hFFFF;
        end
        else begin
            r = x[15:0];
        end
        return r;
    endfunction

endpackage

// ===== src/scpg_queue.sv =====
// Short request queue between the front and back parts.
// Depends on scpg_pkg for the request type and depth.
module scpg_queue
    import scpg_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic wr_en,
    input  req_t wr_data,
    output logic full,
    input  logic rd_en,
    output req_t rd_data,
    output logic empty
);

    req_t           mem [QDEPTH];
    logic [QPW-1:0] wptr_reg, wptr_next;
    logic [QPW-1:0] rptr_reg, rptr_next;
    logic [QCW-1:0] count_reg, count_next;
    logic           do_wr, do_rd;

    assign full = (count_reg == QCW'(QDEPTH));
    assign empty = (count_reg == '0);
    assign do_wr = wr_en && !full;
    assign do_rd = rd_en && !empty;
    assign rd_data = mem[rptr_reg];

    always_comb
    begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        count_next = count_reg;
        if (do_wr)
        begin
            wptr_next = (wptr_reg == QPW'(QDEPTH - 1)) ? '0 : wptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rptr_next = (rptr_reg == QPW'(QDEPTH - 1)) ? '0 : rptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            count_reg <= count_next;
        end
    end

endmodule

// ===== src/scpg_front.sv =====
// Front part: accepts request words, forms the stop distance and sorts each request
// into one of the profile cases. Depends on scpg_pkg.
module scpg_front
    import scpg_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [31:0] route_length,
    input  logic        length_known,
    input  logic [31:0] passage_start_offset,
    input  logic [31:0] passage_end,
    input  logic        borrow_flag,
    input  logic [15:0] ego_speed,
    input  logic [15:0] borrow_limit,
    input  logic [15:0] normal_limit,
    input  logic [16:0] dest_margin,
    input  logic        q_full,
    output logic        q_push,
    output req_t        q_data
);

    logic               valid_reg, valid_next;
    req_t               req_reg, req_next;
    logic               accept;
    logic signed [32:0] stop_dist;
    logic signed [33:0] dest_lim;
    logic [15:0]        speed;
    logic [15:0]        limit;

    assign full = valid_reg && q_full;
    assign accept = push && !full;
    assign q_push = valid_reg;
    assign q_data = req_reg;

    always_comb
    begin
        stop_dist = $signed({route_length[31], route_length})
                  + $signed({passage_start_offset[31], passage_start_offset});
        dest_lim = $signed({{2{passage_end[31]}}, passage_end}) - $signed({17'd0, dest_margin});
        speed = (ego_speed == 16'd0) ? 16'd1 : ego_speed;
        limit = borrow_flag ? borrow_limit : normal_limit;
        req_next.stop_dist = stop_dist[30:0];
        req_next.speed = speed;
        req_next.limit = limit;
        if (!length_known)
        begin
            req_next.kind = K_NO_LENGTH;
        end
        else if ($signed({stop_dist[32], stop_dist}) > dest_lim)
        begin
            req_next.kind = K_DESTINATION;
        end
        else if (stop_dist <= 33'sd1)
        begin
            req_next.kind = K_AT_POINT;
        end
        else if (speed <= limit)
        begin
            req_next.kind = K_BELOW;
        end
        else
        begin
            req_next.kind = K_RAMP;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (valid_reg && !q_full)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ===== src/scpg_back.sv =====
// Back part (uses scpg_pkg): fills the result register with one bound per second or one
// error word; ramps first form braking terms and run a serial divider or square root.
module scpg_back
    import scpg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_empty,
    input  req_t          q_data,
    output logic          q_pop,
    input  logic [15:0]   comfort_decel,
    input  logic [15:0]   max_decel,
    input  logic          pop,
    output logic          empty,
    output logic [1:0]    status,
    output logic [TW-1:0] time_index,
    output logic [15:0]   speed_bound,
    output logic          unbounded,
    output logic          last
);

    back_state_t state_reg, state_next;
    kind_t       kind_reg, kind_next;
    logic [30:0] d_reg, d_next;
    logic [15:0] v_reg, v_next;
    logic [15:0] l_reg, l_next;
    logic [31:0] vv_reg, vv_next;
    logic [31:0] ll_reg, ll_next;
    logic [31:0] av_reg, av_next;
    logic [31:0] adlo_reg, adlo_next;
    logic [30:0] adhi_reg, adhi_next;
    logic [47:0] room_reg, room_next;
    logic [31:0] exc_reg, exc_next;
    logic        roomcase_reg, roomcase_next;
    logic [49:0] wk_reg, wk_next;
    logic [26:0] rem_reg, rem_next;
    logic [24:0] root_reg, root_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [TW-1:0] t_reg, t_next;
    logic [21:0] tv_reg, tv_next;
    logic [21:0] at_reg, at_next;
    logic signed [22:0] mdt_reg, mdt_next;
    logic [39:0] tva_reg, tva_next;

    logic          ovalid_reg, ovalid_next;
    logic [1:0]    ostatus_reg, ostatus_next;
    logic [TW-1:0] ot_reg, ot_next;
    logic [15:0]   obound_reg, obound_next;
    logic          ounb_reg, ounb_next;
    logic          olast_reg, olast_next;

    logic        out_space;
    logic [15:0] a_val;
    logic [46:0] ad_sum;
    logic [17:0] div_trial;
    logic        div_ge;
    logic [26:0] sq_pre, sq_trial;
    logic        sq_ge;
    logic signed [51:0] v_s, l_s, at_s, mdt_s, q_s, vb_s, ramp_md, bound_s;
    logic        unb;

    assign out_space = !ovalid_reg || pop;
    assign empty = !ovalid_reg;
    assign status = ostatus_reg;
    assign time_index = ot_reg;
    assign speed_bound = obound_reg;
    assign unbounded = ounb_reg;
    assign last = olast_reg;
    assign q_pop = (state_reg == BK_IDLE) && !q_empty;

    // Comfort deceleration that is not negative counts as 1 mm/s^2.
    assign a_val = comfort_decel[15] ? (~comfort_decel + 16'd1) : 16'd1;

    assign ad_sum = {adhi_reg, 16'd0} + {15'd0, adlo_reg};
    assign div_trial = {rem_reg[16:0], wk_reg[47]};
    assign div_ge = div_trial >= {1'b0, v_reg, 1'b0};
    assign sq_pre = {rem_reg[24:0], wk_reg[49:48]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_ge = sq_pre >= sq_trial;

    // Bound for the current second.
    always_comb
    begin
        v_s = $signed({36'd0, v_reg});
        l_s = $signed({36'd0, l_reg});
        at_s = $signed({30'd0, at_reg});
        mdt_s = $signed({{29{mdt_reg[22]}}, mdt_reg});
        q_s = $signed({4'd0, wk_reg[47:0]});
        vb_s = $signed({27'd0, root_reg});
        ramp_md = v_s + mdt_s;
        unb = 1'b0;
        case (kind_reg)
            K_AT_POINT:
            begin
                bound_s = smax(l_s, ramp_md);
            end
            K_BELOW:
            begin
                bound_s = l_s;
                unb = {9'd0, tv_reg} < d_reg;
            end
            K_RAMP:
            begin
                if (roomcase_reg)
                begin
                    // The comfort ramp is v - a*t + floor(n / 2v).
                    unb = {8'd0, tva_reg} < room_reg;
                    bound_s = smax(l_s, v_s - at_s + q_s);
                end
                else
                begin
                    bound_s = smax(smax(l_s, vb_s - at_s), ramp_md);
                end
            end
            default:
            begin
                bound_s = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_empty)
                begin
                    case (q_data.kind)
                        K_NO_LENGTH, K_DESTINATION: state_next = BK_EMIT_ERR;
                        K_RAMP: state_next = BK_PREP1;
                        default: state_next = BK_EMIT;
                    endcase
                end
            end
            BK_PREP1: state_next = BK_PREP2;
            BK_PREP2: state_next = BK_PREP3;
            BK_PREP3:
            begin
                state_next = ({16'd0, exc_reg} < room_reg) ? BK_DIV : BK_SQRT;
            end
            BK_DIV, BK_SQRT:
            begin
                if (cnt_reg == 6'd0)
                begin
                    state_next = BK_EMIT;
                end
            end
            BK_EMIT:
            begin
                if (out_space && t_reg == LAST_T)
                begin
                    state_next = BK_IDLE;
                end
            end
            BK_EMIT_ERR:
            begin
                if (out_space)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        kind_next = kind_reg;
        d_next = d_reg;
        v_next = v_reg;
        l_next = l_reg;
        vv_next = vv_reg;
        ll_next = ll_reg;
        av_next = av_reg;
        adlo_next = adlo_reg;
        adhi_next = adhi_reg;
        room_next = room_reg;
        exc_next = exc_reg;
        roomcase_next = roomcase_reg;
        wk_next = wk_reg;
        rem_next = rem_reg;
        root_next = root_reg;
        cnt_next = cnt_reg;
        t_next = t_reg;
        tv_next = tv_reg;
        at_next = at_reg;
        mdt_next = mdt_reg;
        tva_next = tva_reg;
        ovalid_next = ovalid_reg && !pop;
        ostatus_next = ostatus_reg;
        ot_next = ot_reg;
        obound_next = obound_reg;
        ounb_next = ounb_reg;
        olast_next = olast_reg;
        case (state_reg)
            BK_IDLE:
            begin
                kind_next = q_data.kind;
                d_next = q_data.stop_dist;
                v_next = q_data.speed;
                l_next = q_data.limit;
                roomcase_next = 1'b0;
                t_next = '0;
                tv_next = '0;
                at_next = '0;
                mdt_next = '0;
                tva_next = '0;
            end
            BK_PREP1:
            begin
                vv_next = {16'd0, v_reg} * {16'd0, v_reg};
                ll_next = {16'd0, l_reg} * {16'd0, l_reg};
                av_next = {16'd0, a_val} * {16'd0, v_reg};
                adlo_next = {16'd0, a_val} * {16'd0, d_reg[15:0]};
                adhi_next = {15'd0, a_val} * {16'd0, d_reg[30:16]};
            end
            BK_PREP2:
            begin
                room_next = {ad_sum, 1'b0};
                exc_next = vv_reg - ll_reg;
            end
            BK_PREP3:
            begin
                rem_next = '0;
                root_next = '0;
                if ({16'd0, exc_reg} < room_reg)
                begin
                    roomcase_next = 1'b1;
                    room_next = room_reg - {16'd0, exc_reg};
                    wk_next = {2'd0, room_reg - {16'd0, exc_reg}};
                    cnt_next = 6'd47;
                end
                else
                begin
                    wk_next = {2'd0, room_reg} + {18'd0, ll_reg};
                    cnt_next = 6'd24;
                end
            end
            BK_DIV:
            begin
                rem_next = {9'd0, div_ge ? div_trial - {1'b0, v_reg, 1'b0} : div_trial};
                wk_next = {2'd0, wk_reg[46:0], div_ge};
                cnt_next = cnt_reg - 6'd1;
            end
            BK_SQRT:
            begin
                rem_next = sq_ge ? sq_pre - sq_trial : sq_pre;
                root_next = {root_reg[23:0], sq_ge};
                wk_next = {wk_reg[47:0], 2'b00};
                cnt_next = cnt_reg - 6'd1;
            end
            BK_EMIT:
            begin
                if (out_space)
                begin
                    ovalid_next = 1'b1;
                    ostatus_next = ST_POINT;
                    ot_next = t_reg;
                    obound_next = unb ? 16'hFFFF : clamp_bound(bound_s);
                    ounb_next = unb;
                    olast_next = (t_reg == LAST_T);
                    t_next = t_reg + 1'b1;
                    tv_next = tv_reg + {6'd0, v_reg};
                    at_next = at_reg + {6'd0, a_val};
                    mdt_next = mdt_reg + $signed({{7{max_decel[15]}}, max_decel});
                    tva_next = tva_reg + {7'd0, av_reg, 1'b0};
                end
            end
            BK_EMIT_ERR:
            begin
                if (out_space)
                begin
                    ovalid_next = 1'b1;
                    ostatus_next = (kind_reg == K_NO_LENGTH) ? ST_NO_LENGTH : ST_DESTINATION;
                    ot_next = '0;
                    obound_next = 16'd0;
                    ounb_next = 1'b0;
                    olast_next = 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        d_reg <= d_next;
        v_reg <= v_next;
        l_reg <= l_next;
        vv_reg <= vv_next;
        ll_reg <= ll_next;
        av_reg <= av_next;
        adlo_reg <= adlo_next;
        adhi_reg <= adhi_next;
        room_reg <= room_next;
        exc_reg <= exc_next;
        roomcase_reg <= roomcase_next;
        wk_reg <= wk_next;
        rem_reg <= rem_next;
        root_reg <= root_next;
        cnt_reg <= cnt_next;
        t_reg <= t_next;
        tv_reg <= tv_next;
        at_reg <= at_next;
        mdt_reg <= mdt_next;
        tva_reg <= tva_next;
        ostatus_reg <= ostatus_next;
        ot_reg <= ot_next;
        obound_reg <= obound_next;
        ounb_reg <= ounb_next;
        olast_reg <= olast_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

endmodule

// ===== src/speed_cap_profile_generator.sv =====
// A pushed request passes through the front register and the queue before the back part
// takes it in idle. An error request then gives its one word; at-point and below-limit
// requests give one word per cycle for the horizon while the result register has room;
// ramp requests first pass the setup states PREP1, PREP2 and PREP3 and the serial divider
// or square root. The back part takes the next request only after the last word of the
// previous one. Reset clears all control state and loads the register defaults.
// Top level: configuration registers and the front, queue and back parts; uses scpg_pkg.
module speed_cap_profile_generator
    import scpg_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [4:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          push,
    output logic          full,
    input  logic [31:0]   route_length,
    input  logic          length_known,
    input  logic [31:0]   passage_start_offset,
    input  logic [31:0]   passage_end,
    input  logic          borrow_flag,
    input  logic [15:0]   ego_speed,
    input  logic          pop,
    output logic          empty,
    output logic [1:0]    status,
    output logic [TW-1:0] time_index,
    output logic [15:0]   speed_bound,
    output logic          unbounded,
    output logic          last
);

    logic [15:0] borrow_limit_reg, borrow_limit_next;
    logic [15:0] normal_limit_reg, normal_limit_next;
    logic [15:0] comfort_decel_reg, comfort_decel_next;
    logic [15:0] max_decel_reg, max_decel_next;
    logic [16:0] dest_margin_reg, dest_margin_next;
    logic        cfg_wr;

    logic q_full, q_push, q_empty, q_pop;
    req_t q_wdata, q_rdata;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        borrow_limit_next = borrow_limit_reg;
        normal_limit_next = normal_limit_reg;
        comfort_decel_next = comfort_decel_reg;
        max_decel_next = max_decel_reg;
        dest_margin_next = dest_margin_reg;
        if (cfg_wr)
        begin
            case (paddr[4:2])
                REG_BORROW_LIMIT: borrow_limit_next = pwdata[15:0];
                REG_NORMAL_LIMIT: normal_limit_next = pwdata[15:0];
                REG_COMFORT_DECEL: comfort_decel_next = pwdata[15:0];
                REG_MAX_DECEL: max_decel_next = pwdata[15:0];
                REG_DEST_MARGIN: dest_margin_next = pwdata[16:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            REG_BORROW_LIMIT: prdata = {16'd0, borrow_limit_reg};
            REG_NORMAL_LIMIT: prdata = {16'd0, normal_limit_reg};
            REG_COMFORT_DECEL: prdata = {16'd0, comfort_decel_reg};
            REG_MAX_DECEL: prdata = {16'd0, max_decel_reg};
            REG_DEST_MARGIN: prdata = {15'd0, dest_margin_reg};
            default: prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            borrow_limit_reg <= RST_BORROW_LIMIT;
            normal_limit_reg <= RST_NORMAL_LIMIT;
            comfort_decel_reg <= RST_COMFORT_DECEL;
            max_decel_reg <= RST_MAX_DECEL;
            dest_margin_reg <= RST_DEST_MARGIN;
        end
        else
        begin
            borrow_limit_reg <= borrow_limit_next;
            normal_limit_reg <= normal_limit_next;
            comfort_decel_reg <= comfort_decel_next;
            max_decel_reg <= max_decel_next;
            dest_margin_reg <= dest_margin_next;
        end
    end

    scpg_front u_front (
        .clk                  (clk),
        .rst_n                (rst_n),
        .push                 (push),
        .full                 (full),
        .route_length         (route_length),
        .length_known         (length_known),
        .passage_start_offset (passage_start_offset),
        .passage_end          (passage_end),
        .borrow_flag          (borrow_flag),
        .ego_speed            (ego_speed),
        .borrow_limit         (borrow_limit_reg),
        .normal_limit         (normal_limit_reg),
        .dest_margin          (dest_margin_reg),
        .q_full               (q_full),
        .q_push               (q_push),
        .q_data               (q_wdata)
    );

    scpg_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    scpg_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_empty       (q_empty),
        .q_data        (q_rdata),
        .q_pop         (q_pop),
        .comfort_decel (comfort_decel_reg),
        .max_decel     (max_decel_reg),
        .pop           (pop),
        .empty         (empty),
        .status        (status),
        .time_index    (time_index),
        .speed_bound   (speed_bound),
        .unbounded     (unbounded),
        .last          (last)
    );

`ifndef SYNTHESIS
    // An error word is always the only word of its request.
    a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status != ST_POINT) |-> (last && time_index == '0 && speed_bound == 16'd0))
        else $error("error word is not a lone final word");

    // An unbounded second always reads as the full-scale bound.
    a_unb_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && unbounded) |-> (speed_bound == 16'hFFFF && status == ST_POINT))
        else $error("unbounded word with a finite bound");

    // The final word of a profile sits at the last second of the horizon.
    a_last_time: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && status == ST_POINT && last) |-> (time_index == LAST_T))
        else $error("profile ends at the wrong second");
`endif

endmodule
